FILE: design/rfc_pkg.sv
// ----------------------------------------------------------------------------
// Region force competition package
// Shared constants, payload types and the saturation helper.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int MAXR        = 4;
    localparam int NUM_REGIONS = 4;
    localparam int TOP_W       = $clog2(MAXR);
    localparam int CNT_W       = $clog2(MAXR + 1);

    localparam logic [MAXR-1:0] USED_MASK = MAXR'((1 << NUM_REGIONS) - 1);

    typedef logic signed [15:0] t_q88;
    typedef logic signed [16:0] t_score;
    typedef logic signed [17:0] t_diff;
    typedef logic [TOP_W-1:0]   t_idx;

    localparam t_q88  ONE_Q88 = 16'sh0100;
    localparam t_diff Q88_MAX = 18'sd32767;
    localparam t_diff Q88_MIN = -18'sd32768;

    typedef struct packed {
        logic [MAXR-1:0]    mask;
        logic               contested;
        logic               fill;
        t_q88 [MAXR-1:0]    push;
        t_score [MAXR-1:0]  score;
    } t_s1;

    typedef struct packed {
        t_s1    base;
        t_idx   top;
        t_score hi;
    } t_s2;

    typedef struct packed {
        t_s1    base;
        t_idx   top;
        t_score hi;
        t_score nxt;
    } t_s3;

    typedef struct packed {
        logic               contested;
        t_q88 [MAXR-1:0]    new_push;
    } t_res;

    function automatic t_q88 sat_q88(input t_diff v);
        t_q88 res;
        if (v > Q88_MAX) begin
            res = 16'sh7fff;
        end else if (v < Q88_MIN) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

FILE: design/rfc_in_if.sv
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying the band mask, inside bits, forces and
// curvature terms of one pixel.
// ----------------------------------------------------------------------------
interface rfc_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         band_mask;
    logic [3:0]         inside_bits;
    logic signed [15:0] push_0;
    logic signed [15:0] push_1;
    logic signed [15:0] push_2;
    logic signed [15:0] push_3;
    logic signed [15:0] bend_0;
    logic signed [15:0] bend_1;
    logic signed [15:0] bend_2;
    logic signed [15:0] bend_3;

    modport source (
        output valid, band_mask, inside_bits,
        output push_0, push_1, push_2, push_3,
        output bend_0, bend_1, bend_2, bend_3,
        input  ready
    );

    modport sink (
        input  valid, band_mask, inside_bits,
        input  push_0, push_1, push_2, push_3,
        input  bend_0, bend_1, bend_2, bend_3,
        output ready
    );
endinterface

FILE: design/rfc_out_if.sv
// ----------------------------------------------------------------------------
// Resolved force output channel
// Valid/ready channel carrying the resolved forces and the contest flag.
// ----------------------------------------------------------------------------
interface rfc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] new_push_0;
    logic signed [15:0] new_push_1;
    logic signed [15:0] new_push_2;
    logic signed [15:0] new_push_3;
    logic               contested;

    modport source (
        output valid, new_push_0, new_push_1, new_push_2, new_push_3, contested,
        input  ready
    );

    modport sink (
        input  valid, new_push_0, new_push_1, new_push_2, new_push_3, contested,
        output ready
    );
endinterface

FILE: design/rfc_score.sv
// ----------------------------------------------------------------------------
// Region force competition, score stage
// Forms the per-region scores and the overlap and fill decisions.
// ----------------------------------------------------------------------------
module rfc_score import rfc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [MAXR-1:0]     i_mask,
    input  logic [MAXR-1:0]     i_inside,
    input  t_q88 [MAXR-1:0]     i_push,
    input  t_q88 [MAXR-1:0]     i_bend,
    output logic                o_valid,
    output t_s1                 o_data,
    input  logic                i_ready
);

    logic             r_v;
    t_s1              r_s1;
    t_s1              n_s1;
    logic [MAXR-1:0]  inside_used;
    logic [CNT_W-1:0] n_masked;
    logic [CNT_W-1:0] n_insides;

    always_comb begin
        inside_used = i_inside & USED_MASK;
        n_s1.mask   = i_mask & USED_MASK;
        n_s1.push   = i_push;
        n_masked    = '0;
        n_insides   = '0;
        for (int r = 0; r < MAXR; r++) begin
            n_s1.score[r] = t_score'(i_push[r]) - t_score'(i_bend[r]);
            n_masked      = n_masked + CNT_W'(n_s1.mask[r]);
            n_insides     = n_insides + CNT_W'(inside_used[r]);
        end
        n_s1.contested = (n_masked > CNT_W'(1));
        n_s1.fill      = !n_s1.contested && (n_insides <= CNT_W'(1));
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

endmodule

FILE: design/rfc_rank.sv
// ----------------------------------------------------------------------------
// Region force competition, ranking stages
// Finds the top scorer and its score, then the runner-up score.
// ----------------------------------------------------------------------------
module rfc_rank import rfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_s1     i_data,
    output logic    o_valid,
    output t_s3     o_data,
    input  logic    i_ready
);

    logic   r_v2;
    logic   r_v3;
    t_s2    r_s2;
    t_s3    r_s3;
    t_s2    n_s2;
    t_s3    n_s3;
    logic   found_hi;
    logic   found_nxt;
    logic   ready3;

    // Lowest index wins among equal highest scores.
    always_comb begin
        found_hi = 1'b0;
        n_s2.base = i_data;
        n_s2.top  = '0;
        n_s2.hi   = '0;
        for (int r = 0; r < MAXR; r++) begin
            if (i_data.mask[r] && (!found_hi || i_data.score[r] > n_s2.hi)) begin
                found_hi  = 1'b1;
                n_s2.top  = t_idx'(r);
                n_s2.hi   = i_data.score[r];
            end
        end
    end

    always_comb begin
        found_nxt = 1'b0;
        n_s3.base = r_s2.base;
        n_s3.top  = r_s2.top;
        n_s3.hi   = r_s2.hi;
        n_s3.nxt  = '0;
        for (int r = 0; r < MAXR; r++) begin
            if (r_s2.base.mask[r] && (t_idx'(r) != r_s2.top) &&
                (!found_nxt || r_s2.base.score[r] > n_s3.nxt)) begin
                found_nxt = 1'b1;
                n_s3.nxt  = r_s2.base.score[r];
            end
        end
    end

    assign ready3  = !r_v3 || i_ready;
    assign o_ready = !r_v2 || ready3;
    assign o_valid = r_v3;
    assign o_data  = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
        if (ready3 && r_v2) begin
            r_s3 <= n_s3;
        end
    end

`ifndef NO_ASSERTIONS
    a_top_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_s3.base.contested |-> r_s3.base.mask[r_s3.top])
        else $error("Top scorer is not a masked region.");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_s3.base.contested |-> r_s3.hi >= r_s3.nxt)
        else $error("Runner-up score exceeds the top score.");

    a_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_s2.base.contested |-> !r_s2.base.fill)
        else $error("Contested pixel is also marked for fill.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_ready |=> r_v3 && $stable(r_s3))
        else $error("Ranked item changed while stalled.");
`endif

endmodule

FILE: design/rfc_resolve.sv
// ----------------------------------------------------------------------------
// Region force competition, resolve stage
// Subtracts the competing score, applies the fill constant and saturates.
// ----------------------------------------------------------------------------
module rfc_resolve import rfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_s3     i_data,
    output logic    o_valid,
    output t_res    o_data,
    input  logic    i_ready
);

    logic   r_v;
    t_res   r_res;
    t_res   n_res;
    t_score sel;

    always_comb begin
        sel = '0;
        n_res.contested = i_data.base.contested;
        for (int r = 0; r < MAXR; r++) begin
            sel = (t_idx'(r) == i_data.top) ? i_data.nxt : i_data.hi;
            if (i_data.base.contested && i_data.base.mask[r]) begin
                n_res.new_push[r] = sat_q88(t_diff'(i_data.base.push[r]) - t_diff'(sel));
            end else if (i_data.base.fill && i_data.base.mask[r] &&
                         i_data.base.push[r] <= 16'sd0) begin
                n_res.new_push[r] = ONE_Q88;
            end else begin
                n_res.new_push[r] = i_data.base.push[r];
            end
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule

FILE: design/region_force_competition_unit.sv
// ----------------------------------------------------------------------------
// Region force competition unit
// Resolves the normal forces of up to four level-set regions meeting in one
// pixel.
// ----------------------------------------------------------------------------
// One pixel enters on i_pix per transfer and one result leaves on o_res per
// transfer, in the same order. Where two or more band-mask bits are set the
// regions compete on push minus bend; otherwise masked regions with a force
// at or below zero take 1.0 when at most one inside bit is set. Results are
// saturated signed Q8.8.
// The datapath is four register stages: scoring, top-scorer search,
// runner-up search and the subtract with saturation. A pixel passes them in
// order, and one pixel can be taken every cycle while o_res is not stalled.
// Each stage has its own valid bit and moves on whenever the stage after it
// is empty or moving, so bubbles close up under back-pressure.
// When the receiver stalls the pipeline fills and holds; i_pix.ready falls
// only once all four stages are occupied. Nothing is lost or repeated.
// Reset clears every valid bit; no results are pending afterwards.
// ----------------------------------------------------------------------------
module region_force_competition_unit import rfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfc_in_if.sink      i_pix,
    rfc_out_if.source   o_res
);

    t_q88 [MAXR-1:0] push_in;
    t_q88 [MAXR-1:0] bend_in;
    logic            s1_valid;
    logic            s1_ready;
    t_s1             s1_data;
    logic            s3_valid;
    logic            s3_ready;
    t_s3             s3_data;
    t_res            res_data;

    assign push_in[0] = i_pix.push_0;
    assign push_in[1] = i_pix.push_1;
    assign push_in[2] = i_pix.push_2;
    assign push_in[3] = i_pix.push_3;
    assign bend_in[0] = i_pix.bend_0;
    assign bend_in[1] = i_pix.bend_1;
    assign bend_in[2] = i_pix.bend_2;
    assign bend_in[3] = i_pix.bend_3;

    rfc_score u_score (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_mask   (i_pix.band_mask),
        .i_inside (i_pix.inside_bits),
        .i_push   (push_in),
        .i_bend   (bend_in),
        .o_valid  (s1_valid),
        .o_data   (s1_data),
        .i_ready  (s1_ready)
    );

    rfc_rank u_rank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s1_ready),
        .i_data   (s1_data),
        .o_valid  (s3_valid),
        .o_data   (s3_data),
        .i_ready  (s3_ready)
    );

    rfc_resolve u_resolve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .o_ready  (s3_ready),
        .i_data   (s3_data),
        .o_valid  (o_res.valid),
        .o_data   (res_data),
        .i_ready  (o_res.ready)
    );

    assign o_res.new_push_0 = res_data.new_push[0];
    assign o_res.new_push_1 = res_data.new_push[1];
    assign o_res.new_push_2 = res_data.new_push[2];
    assign o_res.new_push_3 = res_data.new_push[3];
    assign o_res.contested  = res_data.contested;

endmodule
